// ===== sv/svt_pkg.sv =====
`timescale 1ns / 1ps
package svt_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 8;
  localparam int POS_W        = 8;
  localparam int CNT_W        = 9;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_MODIFY = 2'd1,
    OP_APPEND = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Control part of the item token that walks down the cell chain
  typedef struct packed {
    logic    valid;
    opcode_t op;
    logic    wr;
    logic    found;
    status_t status;
  } ctl_t;

endpackage

// ===== sv/svt_cell.sv =====
`timescale 1ns / 1ps
module svt_cell
  import svt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  ctl_t                        in_ctl,
  input  logic [$clog2(CAPACITY)-1:0] in_target,
  input  logic [DATA_W-1:0]           in_key,
  input  logic [DATA_W-1:0]           in_old,
  input  logic [$clog2(CAPACITY)-1:0] in_pos,
  output ctl_t                        out_ctl,
  output logic [$clog2(CAPACITY)-1:0] out_target,
  output logic [DATA_W-1:0]           out_key,
  output logic [DATA_W-1:0]           out_old,
  output logic [$clog2(CAPACITY)-1:0] out_pos
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] IDX_P = PW'(CELL_IDX);
  localparam logic [CW-1:0] IDX_C = CW'(CELL_IDX);

  logic [DATA_W-1:0] entry_r, entry_nxt;
  ctl_t              ctl_r, ctl_nxt;
  logic [PW-1:0]     target_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] old_r, old_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              hit;
  logic              match;

  // Decide whether this cell is written or matches the search key
  always_comb begin
    hit   = in_ctl.valid && in_ctl.wr && (in_target == IDX_P);
    match = in_ctl.valid && (in_ctl.op == OP_SEARCH) && !in_ctl.found &&
            (IDX_C < count) && (entry_r == in_key);
  end

  // Update the entry and the token that moves on
  always_comb begin
    entry_nxt = entry_r;
    if (hit) begin
      entry_nxt = (in_ctl.op == OP_CLEAR) ? '0 : in_key;
    end
    ctl_nxt = in_ctl;
    if (match) begin
      ctl_nxt.found = 1'b1;
    end
    old_nxt = (hit && (in_ctl.op == OP_MODIFY)) ? entry_r : in_old;
    pos_nxt = match ? IDX_P : in_pos;
  end

  // Hold the entry; it is defined once an append has written it
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Advance the token by one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r <= in_target;
    key_r    <= in_key;
    old_r    <= old_nxt;
    pos_r    <= pos_nxt;
  end

  assign out_ctl    = ctl_r;
  assign out_target = target_r;
  assign out_key    = key_r;
  assign out_old    = old_r;
  assign out_pos    = pos_r;

endmodule

// ===== sv/searchable_value_table.sv =====
`timescale 1ns / 1ps
// Table of CAPACITY signed 32-bit entries with a used-entry count.
// Input channel: drive in_opcode, in_index and in_value and raise start; the
// item is taken at the clock edge where start is high and busy is low.
// Opcodes: search for the lowest used entry equal to in_value, modify the
// entry at in_index, append in_value at the end, clear the entry at in_index.
// Result channel: out_valid is high for exactly one cycle with out_status,
// out_position, out_old_value and out_entry_count. The receiver cannot stall;
// the result must be taken in that cycle.
// The item token is registered at the head and then passes one cell per cycle
// down a row of CAPACITY cells, each holding one entry; the result comes from
// the token leaving the last cell. busy drops in the strobe cycle, so a new
// item can be taken at the edge that ends it, but not before the last item's
// result strobe.
// Reset: rst_n (synchronous, active low) empties the table (count zero) and
// drops any item in flight. Entries are not cleared; an entry is read only
// once an append has written it.
module searchable_value_table
  import svt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic [IDX_W-1:0]         in_index,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [POS_W-1:0]         out_position,
  output logic signed [DATA_W-1:0] out_old_value,
  output logic [CNT_W-1:0]         out_entry_count
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          accept;
  logic          in_range;
  logic          full;
  opcode_t       op;

  ctl_t          head_ctl_nxt;
  logic [PW-1:0] head_target_nxt;

  // Token stage signals; stage 0 is the head register, stage k+1 leaves cell k
  ctl_t              ctl_c    [CAPACITY+1];
  logic [PW-1:0]     target_c [CAPACITY+1];
  logic [DATA_W-1:0] key_c    [CAPACITY+1];
  logic [DATA_W-1:0] old_c    [CAPACITY+1];
  logic [PW-1:0]     pos_c    [CAPACITY+1];
  logic [CAPACITY:0] vld_vec;

  ctl_t              head_ctl_r;
  logic [PW-1:0]     head_target_r;
  logic [DATA_W-1:0] head_key_r;

  assign op       = opcode_t'(in_opcode);
  assign accept   = start && !busy;
  assign in_range = XW'(in_index) < XW'(count_r);
  assign full     = (count_r == CW'(CAPACITY));
  assign out_valid = ctl_c[CAPACITY].valid;
  assign busy     = (state_r == S_RUN) && !out_valid;

  // Check range and fullness up front, build the token and count an append
  always_comb begin
    head_ctl_nxt        = '0;
    head_ctl_nxt.valid  = accept;
    head_ctl_nxt.op     = op;
    head_target_nxt     = PW'(in_index);
    count_nxt           = count_r;
    unique case (op)
      OP_SEARCH: begin
        head_ctl_nxt.status = ST_NOT_FOUND;
      end
      OP_MODIFY, OP_CLEAR: begin
        head_ctl_nxt.wr     = in_range;
        head_ctl_nxt.status = in_range ? ST_OK : ST_RANGE;
      end
      OP_APPEND: begin
        head_ctl_nxt.wr     = !full;
        head_ctl_nxt.status = full ? ST_FULL : ST_OK;
        head_target_nxt     = PW'(count_r);
        if (accept && !full) begin
          count_nxt = count_r + CW'(1);
        end
      end
      default: begin
        head_ctl_nxt.status = ST_NOT_FOUND;
      end
    endcase
  end

  // Sequence one item at a time; a new item may enter in the strobe cycle
  always_comb begin
    state_nxt = state_r;
    priority if (accept) begin
      state_nxt = S_RUN;
    end else if (out_valid) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      head_ctl_r <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      head_ctl_r <= head_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_target_r <= head_target_nxt;
    head_key_r    <= in_value;
  end

  assign ctl_c[0]    = head_ctl_r;
  assign target_c[0] = head_target_r;
  assign key_c[0]    = head_key_r;
  assign old_c[0]    = '0;
  assign pos_c[0]    = '0;

  // Row of cells, one entry each
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    svt_cell #(
      .CAPACITY (CAPACITY),
      .CELL_IDX (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .count      (count_r),
      .in_ctl     (ctl_c[k]),
      .in_target  (target_c[k]),
      .in_key     (key_c[k]),
      .in_old     (old_c[k]),
      .in_pos     (pos_c[k]),
      .out_ctl    (ctl_c[k+1]),
      .out_target (target_c[k+1]),
      .out_key    (key_c[k+1]),
      .out_old    (old_c[k+1]),
      .out_pos    (pos_c[k+1])
    );
  end

  for (genvar k = 0; k <= CAPACITY; k++) begin : g_vld
    assign vld_vec[k] = ctl_c[k].valid;
  end

  // Drive the result from the token leaving the last cell
  always_comb begin
    if (ctl_c[CAPACITY].op == OP_SEARCH) begin
      out_status = ctl_c[CAPACITY].found ? ST_OK : ST_NOT_FOUND;
    end else begin
      out_status = ctl_c[CAPACITY].status;
    end
  end

  assign out_position    = POS_W'(pos_c[CAPACITY]);
  assign out_old_value   = old_c[CAPACITY];
  assign out_entry_count = CNT_W'(count_r);

  // At most one item travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) <= 1)
    else $error("more than one item in the cell chain");

  // A result only appears while an item is being worked
  a_strobe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_RUN))
    else $error("result strobe outside of a running item");

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("used count beyond capacity");

  // A full report means the table really is full
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (count_r == CW'(CAPACITY)))
    else $error("table full reported with room left");

endmodule
